### rtl/sitrd_pkg.sv
// Shared types, constants and helpers for the signed integer to radix text unit.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package sitrd_pkg;

   // fixed field and register widths
   localparam int NUMBER_W       = 32;
   localparam int CHAR_W         = 7;
   localparam int BYTE_W         = 8;
   localparam int COUNT_W        = 6;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int TABLE_BYTES    = 32;
   localparam int TABLE_PTR_W    = 5;
   localparam int BYTES_PER_WORD = CSR_DATA_W / BYTE_W;
   localparam int TABLE_WORDS    = TABLE_BYTES / BYTES_PER_WORD;

   // parameter defaults
   localparam int DEFAULT_MAX_BASE    = 32;
   localparam int DEFAULT_NUMBER_BITS = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGITS_FIRST = 3'd1;

   localparam logic [COUNT_W-1:0] MIN_COUNT = 6'd2;

   // character codes
   localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd33;
   localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;

   typedef logic [TABLE_BYTES-1:0][BYTE_W-1:0] digit_table_type;

   typedef struct packed {
      logic busy;
      logic ok;
   } chk_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_SIGN,
      ST_DIGITS,
      ST_ERROR
   } conv_state_type;

   // printable and not an operator or separator
   function automatic logic char_allowed(input logic [BYTE_W-1:0] c);
      logic printable;
      logic reserved;
      printable = c inside {[PRINT_LO:PRINT_HI]};
      reserved  = c inside {CH_PLUS, CH_MINUS, CH_PERCENT, CH_SLASH,
                            CH_STAR, CH_EQUALS, CH_COMMA, CH_DOT};
      return printable && !reserved;
   endfunction

endpackage

`default_nettype wire

### rtl/sitrd_table_check.sv
// Digit table checker: scans a shifted copy of the table one digit per cycle.
// Depends on sitrd_pkg.
`default_nettype none

module sitrd_table_check #(
   parameter int MAX_BASE = sitrd_pkg::DEFAULT_MAX_BASE
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cfg_written,
   input  wire sitrd_pkg::digit_table_type       digit_table,
   input  wire logic [sitrd_pkg::COUNT_W-1:0]    digit_count,
   output sitrd_pkg::chk_status_type             status
);
   import sitrd_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BASE);

   logic                   start_ff;
   digit_table_type        shift_ff, shift_in;
   logic [TABLE_BYTES-1:0] mask_ff, mask_in;
   logic                   ok_ff, ok_in;
   logic                   dup;
   logic                   head_bad;

   // head digit against every later digit still inside the count
   always_comb begin
      dup = 1'b0;
      for (int p = 1; p < TABLE_BYTES; p++) begin
         if (mask_ff[p] && (shift_ff[p] == shift_ff[0])) begin
            dup = 1'b1;
         end
      end
   end

   assign head_bad = mask_ff[0] && (!char_allowed(shift_ff[0]) || dup);

   always_comb begin
      if (start_ff) begin
         shift_in = digit_table;
         for (int j = 0; j < TABLE_BYTES; j++) begin
            mask_in[j] = COUNT_W'(j) < digit_count;
         end
         ok_in = (digit_count >= MIN_COUNT) && (digit_count <= MAX_COUNT);
      end else begin
         shift_in = digit_table_type'(shift_ff >> BYTE_W);
         mask_in  = mask_ff >> 1;
         ok_in    = ok_ff && !head_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         mask_ff  <= '0;
         ok_ff    <= 1'b0;
      end else begin
         start_ff <= cfg_written;
         mask_ff  <= mask_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign status.busy = start_ff | (|mask_ff);
   assign status.ok   = ok_ff;

endmodule

`default_nettype wire

### rtl/sitrd_digit_array.sv
// Systolic radix converter: magnitude bits enter MSB first, each lane doubles its
// digit mod radix and passes the carry, registered, to the next lane. Uses sitrd_pkg.
`default_nettype none

module sitrd_digit_array #(
   parameter int NUMBER_BITS = sitrd_pkg::DEFAULT_NUMBER_BITS,
   parameter int MAX_BASE    = sitrd_pkg::DEFAULT_MAX_BASE,
   localparam int LANES      = NUMBER_BITS,
   localparam int DIGIT_W    = $clog2(MAX_BASE),
   localparam int LANE_W     = $clog2(LANES)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [NUMBER_BITS-1:0] magnitude,
   input  wire logic [DIGIT_W:0]       radix,
   output logic                        busy,
   input  wire logic [LANE_W-1:0]      rd_lane,
   output logic [DIGIT_W-1:0]          rd_digit,
   output logic [LANE_W-1:0]           top_lane
);
   import sitrd_pkg::*;

   localparam int CNT_W = $clog2(NUMBER_BITS + 1);

   logic [NUMBER_BITS-1:0]             mag_ff, mag_in;
   logic [CNT_W-1:0]                   bits_left_ff, bits_left_in;
   logic [LANES-1:0]                   lane_v_ff;
   logic [LANES-2:0]                   lane_c_ff, carry_out;
   logic [LANES-1:0][DIGIT_W-1:0]      digit_ff, digit_in;
   logic [LANES-1:0][DIGIT_W:0]        lane_sum;
   logic [LANES-1:0]                   in_v, in_c;
   logic                               feeding;

   assign feeding = bits_left_ff != '0;
   assign in_v    = {lane_v_ff[LANES-2:0], feeding};
   assign in_c    = {lane_c_ff, mag_ff[NUMBER_BITS-1]};

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lane_sum[k] = {digit_ff[k], in_c[k]};
      end
      for (int k = 0; k < LANES - 1; k++) begin
         carry_out[k] = lane_sum[k] >= radix;
      end
      for (int k = 0; k < LANES; k++) begin
         if (start) begin
            digit_in[k] = '0;
         end else if (!in_v[k]) begin
            digit_in[k] = digit_ff[k];
         end else if (lane_sum[k] >= radix) begin
            digit_in[k] = DIGIT_W'(lane_sum[k] - radix);
         end else begin
            digit_in[k] = lane_sum[k][DIGIT_W-1:0];
         end
      end
   end

   always_comb begin
      if (start) begin
         mag_in       = magnitude;
         bits_left_in = CNT_W'(NUMBER_BITS);
      end else if (feeding) begin
         mag_in       = mag_ff << 1;
         bits_left_in = bits_left_ff - 1'b1;
      end else begin
         mag_in       = mag_ff;
         bits_left_in = bits_left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff <= '0;
         lane_v_ff    <= '0;
      end else begin
         bits_left_ff <= bits_left_in;
         lane_v_ff    <= start ? '0 : in_v;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      digit_ff  <= digit_in;
      lane_c_ff <= carry_out;
   end

   assign busy = feeding | (|lane_v_ff);

   // most significant non-zero lane, lane 0 when the value is zero
   always_comb begin
      top_lane = '0;
      for (int k = 0; k < LANES; k++) begin
         if (digit_ff[k] != '0) begin
            top_lane = LANE_W'(k);
         end
      end
   end

   assign rd_digit = digit_ff[rd_lane];

endmodule

`default_nettype wire

### rtl/signed_int_to_radix_digits_unit.sv
// Signed integer to radix text unit, top level.
// Instantiates sitrd_table_check and sitrd_digit_array; uses sitrd_pkg.
//
// Use:
//  - req_ channel takes one signed word (req_number); only its low NUMBER_BITS
//    bits count, read as two's complement.
//  - rsp_ channel gives one ASCII character per word, most significant digit
//    first, a leading '-' for negatives; rsp_is_last marks the final one.
//  - csr_ port writes the digit count (index 0) and the 32-byte digit table
//    (indexes 1 to 4, eight digits each). Unknown indexes are ignored.
//  - Each write starts a table scan (one digit a cycle); req_stall stays high
//    until it ends. A bad table turns every request into one word with
//    rsp_table_invalid set, a zero character and rsp_is_last.
//  - Conversion: the magnitude is shifted into a row of NUMBER_BITS digit
//    lanes, one bit a cycle, carries passing lane to lane through registers.
//    Once the digits settle, one character leaves per cycle while rsp_stall
//    is low. One request is in flight at a time.
//  - The output register frees the converter: a new request is taken while
//    the last character still waits. A stalled rsp_ word holds; the output
//    sequencer simply pauses until rsp_stall drops.
//  - Reset clears the configuration and control registers; the table then counts as invalid.
`default_nettype none

module signed_int_to_radix_digits_unit #(
   parameter int MAX_BASE    = sitrd_pkg::DEFAULT_MAX_BASE,
   parameter int NUMBER_BITS = sitrd_pkg::DEFAULT_NUMBER_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [sitrd_pkg::NUMBER_W-1:0] req_number,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [sitrd_pkg::CHAR_W-1:0]              rsp_character,
   output logic                                      rsp_is_last,
   output logic                                      rsp_table_invalid,
   // configuration port
   input  wire logic                                 csr_write,
   input  wire logic [sitrd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sitrd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sitrd_pkg::*;

   localparam int DIGIT_W = $clog2(MAX_BASE);
   localparam int LANE_W  = $clog2(NUMBER_BITS);

   // configuration registers
   logic [COUNT_W-1:0] digit_count_ff;
   digit_table_type    digit_table_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= '0;
         digit_table_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_DIGIT_COUNT) begin
            digit_count_ff <= csr_data[COUNT_W-1:0];
         end
         for (int w = 0; w < TABLE_WORDS; w++) begin
            if (csr_index == CSR_DIGITS_FIRST + CSR_INDEX_W'(w)) begin
               digit_table_ff[w*BYTES_PER_WORD +: BYTES_PER_WORD] <= csr_data;
            end
         end
      end
   end

   // table scan, restarted by every write
   chk_status_type chk_status;

   sitrd_table_check #(
      .MAX_BASE (MAX_BASE)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .cfg_written (csr_write),
      .digit_table (digit_table_ff),
      .digit_count (digit_count_ff),
      .status      (chk_status)
   );

   // request side
   conv_state_type         state_ff, state_in;
   logic                   accept;
   logic [NUMBER_BITS-1:0] raw;
   logic [NUMBER_BITS-1:0] magnitude;
   logic                   negative_ff;

   assign req_stall = !((state_ff == ST_IDLE) && !chk_status.busy);
   assign accept    = req_valid && !req_stall;
   assign raw       = req_number[NUMBER_BITS-1:0];
   // most negative value maps onto itself, which is right read unsigned
   assign magnitude = raw[NUMBER_BITS-1] ? (~raw + 1'b1) : raw;

   always_ff @(posedge clock) begin
      if (accept) begin
         negative_ff <= raw[NUMBER_BITS-1];
      end
   end

   // digit lanes
   logic                arr_busy;
   logic [LANE_W-1:0]   ptr_ff, ptr_in;
   logic [DIGIT_W-1:0]  rd_digit;
   logic [LANE_W-1:0]   top_lane;

   sitrd_digit_array #(
      .NUMBER_BITS (NUMBER_BITS),
      .MAX_BASE    (MAX_BASE)
   ) u_array (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && chk_status.ok),
      .magnitude (magnitude),
      .radix     (digit_count_ff[DIGIT_W:0]),
      .busy      (arr_busy),
      .rd_lane   (ptr_ff),
      .rd_digit  (rd_digit),
      .top_lane  (top_lane)
   );

   // output register
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_character_ff;
   logic              rsp_is_last_ff;
   logic              rsp_table_invalid_ff;
   logic              out_free;
   logic              out_load;
   logic [CHAR_W-1:0] out_char;
   logic              out_last;
   logic              out_bad;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = chk_status.ok ? ST_RUN : ST_ERROR;
            end
         end
         ST_RUN: begin
            if (!arr_busy) begin
               state_in = negative_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free && (ptr_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      out_load = 1'b0;
      out_char = '0;
      out_last = 1'b0;
      out_bad  = 1'b0;
      ptr_in   = ptr_ff;
      case (state_ff)
         ST_RUN: begin
            if (!arr_busy) begin
               ptr_in = top_lane;
            end
         end
         ST_SIGN: begin
            out_load = out_free;
            out_char = CH_MINUS[CHAR_W-1:0];
         end
         ST_DIGITS: begin
            out_load = out_free;
            out_char = digit_table_ff[TABLE_PTR_W'(rd_digit)][CHAR_W-1:0];
            out_last = ptr_ff == '0;
            if (out_free && (ptr_ff != '0)) begin
               ptr_in = ptr_ff - 1'b1;
            end
         end
         ST_ERROR: begin
            out_load = out_free;
            out_last = 1'b1;
            out_bad  = 1'b1;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (out_load) begin
         rsp_character_ff     <= out_char;
         rsp_is_last_ff       <= out_last;
         rsp_table_invalid_ff <= out_bad;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_character     = rsp_character_ff;
   assign rsp_is_last       = rsp_is_last_ff;
   assign rsp_table_invalid = rsp_table_invalid_ff;

endmodule

`default_nettype wire
